### hw/rtl/cfq_pkg.sv
// Shared types, codes and constants of the circular FIFO queue.
package cfq_pkg;

	localparam int DEPTH_DEF   = 16;  // default storage depth
	localparam int CAP_W       = 5;   // capacity and held count width
	localparam int DATA_W      = 32;  // stored word width
	localparam int POS_W       = 4;   // reported slot index width
	localparam int SHOW_MAX    = 16;  // most results one show gives
	localparam int CAP_RST_MAX = 16;  // capacity after reset, at most

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_SHOW   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_RUN  = 1'b1
	} state_t;

	typedef struct packed {
		logic             wr;
		logic [CAP_W-1:0] cap_new;
	} cfg_wr_t;

	typedef struct packed {
		logic             busy;
		logic [CAP_W-1:0] held;
	} ctrl_stat_t;

	function automatic logic [CAP_W-1:0] cap_reset(input int depth);
		return (depth < CAP_RST_MAX) ? CAP_W'(depth) : CAP_W'(CAP_RST_MAX);
	endfunction

endpackage

### hw/rtl/cfq_ram.sv
// Slot storage: one write port, one registered read port.
module cfq_ram #(
	parameter int DEPTH  = cfq_pkg::DEPTH_DEF,
	parameter int DATA_W = cfq_pkg::DATA_W,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### hw/rtl/cfq_ctrl.sv
// Queue controller: pointers, held count, read sequencing and output register.
module cfq_ctrl #(
	parameter int DEPTH = cfq_pkg::DEPTH_DEF,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [cfq_pkg::CAP_W-1:0]   cap,
	input  cfq_pkg::cfg_wr_t            cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  in_kind,
	input  logic [cfq_pkg::DATA_W-1:0]  in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  out_status,
	output logic [cfq_pkg::DATA_W-1:0]  out_value,
	output logic [cfq_pkg::POS_W-1:0]   out_front,
	output logic [cfq_pkg::POS_W-1:0]   out_rear,
	output logic                        out_last,
	output logic                        mem_we,
	output logic [AW-1:0]               mem_waddr,
	output logic [cfq_pkg::DATA_W-1:0]  mem_wdata,
	output logic                        mem_re,
	output logic [AW-1:0]               mem_raddr,
	input  logic [cfq_pkg::DATA_W-1:0]  mem_rdata,
	output cfq_pkg::ctrl_stat_t         stat
);

	localparam int CW = cfq_pkg::CAP_W;
	localparam logic [CW-1:0] CAP_RST = cfq_pkg::cap_reset(DEPTH);

	function automatic logic [AW-1:0] wrap_next(input logic [AW-1:0] i,
	                                            input logic [CW-1:0] c);
		logic [CW:0] n;
		n = (CW+1)'(i) + (CW+1)'(1);
		return (n >= {1'b0, c}) ? '0 : AW'(n);
	endfunction

	cfq_pkg::state_t state_q, state_d;
	logic [AW-1:0]   front_q, front_d, rear_q, rear_d, pos_q, pos_d;
	logic [CW-1:0]   held_q, held_d, cnt_q, cnt_d, lim_q, lim_d;
	logic            show_q, show_d, pend_q, pend_d, plast_q, plast_d;
	logic            ov_q, ov_d;

	// output payload
	logic [1:0]                 ostat_q;
	logic [cfq_pkg::DATA_W-1:0] oval_q;
	logic [cfq_pkg::POS_W-1:0]  ofront_q, orear_q;
	logic                       olast_q;

	logic                       ld;
	logic [1:0]                 ld_stat;
	logic [cfq_pkg::DATA_W-1:0] ld_val;
	logic [cfq_pkg::POS_W-1:0]  ld_front, ld_rear;
	logic                       ld_last;

	logic out_free, accept, load, more, issue;

	assign out_free = !ov_q || out_ready;
	assign in_ready = (state_q == cfq_pkg::S_IDLE) && out_free;
	assign accept   = in_valid && in_ready;
	assign load     = (state_q == cfq_pkg::S_RUN) && pend_q && out_free;
	assign more     = (cnt_q != lim_q);
	assign issue    = (state_q == cfq_pkg::S_RUN) && more && (!pend_q || load);

	always_comb begin
		state_d   = state_q;
		front_d   = front_q;
		rear_d    = rear_q;
		held_d    = held_q;
		pos_d     = pos_q;
		cnt_d     = cnt_q;
		lim_d     = lim_q;
		show_d    = show_q;
		pend_d    = pend_q;
		plast_d   = plast_q;
		ov_d      = ov_q && !out_ready;
		ld        = 1'b0;
		ld_stat   = cfq_pkg::ST_OK;
		ld_val    = '0;
		ld_front  = '0;
		ld_rear   = '0;
		ld_last   = 1'b1;
		mem_we    = 1'b0;
		mem_waddr = wrap_next(rear_q, cap);
		mem_wdata = in_data;
		mem_re    = 1'b0;
		mem_raddr = pos_q;

		case (state_q)
			cfq_pkg::S_IDLE: begin
				if (accept) begin
					case (in_kind)
						cfq_pkg::KIND_INSERT: begin
							if (held_q >= cap) begin
								ld      = 1'b1;
								ld_stat = cfq_pkg::ST_FULL;
							end else begin
								mem_we = 1'b1;
								rear_d = wrap_next(rear_q, cap);
								held_d = held_q + CW'(1);
							end
						end
						cfq_pkg::KIND_REMOVE: begin
							if (held_q == '0) begin
								ld      = 1'b1;
								ld_stat = cfq_pkg::ST_EMPTY;
							end else begin
								pos_d   = front_q;
								cnt_d   = '0;
								lim_d   = CW'(1);
								show_d  = 1'b0;
								state_d = cfq_pkg::S_RUN;
								// last word out: pointers go back home
								if (held_q == CW'(1)) begin
									front_d = '0;
									rear_d  = AW'(cap - CW'(1));
									held_d  = '0;
								end else begin
									front_d = wrap_next(front_q, cap);
									held_d  = held_q - CW'(1);
								end
							end
						end
						cfq_pkg::KIND_SHOW: begin
							if (held_q == '0) begin
								ld      = 1'b1;
								ld_stat = cfq_pkg::ST_EMPTY;
							end else begin
								pos_d   = front_q;
								cnt_d   = '0;
								lim_d   = (held_q > CW'(cfq_pkg::SHOW_MAX)) ?
								          CW'(cfq_pkg::SHOW_MAX) : held_q;
								show_d  = 1'b1;
								state_d = cfq_pkg::S_RUN;
							end
						end
						default: begin
						end
					endcase
				end
			end
			cfq_pkg::S_RUN: begin
				if (load) begin
					ld       = 1'b1;
					ld_stat  = cfq_pkg::ST_OK;
					ld_val   = mem_rdata;
					ld_front = show_q ? cfq_pkg::POS_W'(front_q) : '0;
					ld_rear  = show_q ? cfq_pkg::POS_W'(rear_q) : '0;
					ld_last  = plast_q;
					pend_d   = 1'b0;
				end
				if (issue) begin
					mem_re  = 1'b1;
					pos_d   = wrap_next(pos_q, cap);
					cnt_d   = cnt_q + CW'(1);
					pend_d  = 1'b1;
					plast_d = show_q ? (cnt_q + CW'(1) == held_q) : 1'b1;
				end
				if (!more && (!pend_q || load)) begin
					state_d = cfq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = cfq_pkg::S_IDLE;
			end
		endcase

		if (ld) begin
			ov_d = 1'b1;
		end

		// a new capacity empties the queue
		if (cfg.wr) begin
			front_d = '0;
			rear_d  = AW'(cfg.cap_new - CW'(1));
			held_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cfq_pkg::S_IDLE;
			front_q <= '0;
			rear_q  <= AW'(CAP_RST - CW'(1));
			held_q  <= '0;
			pos_q   <= '0;
			cnt_q   <= '0;
			lim_q   <= '0;
			show_q  <= 1'b0;
			pend_q  <= 1'b0;
			plast_q <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			rear_q  <= rear_d;
			held_q  <= held_d;
			pos_q   <= pos_d;
			cnt_q   <= cnt_d;
			lim_q   <= lim_d;
			show_q  <= show_d;
			pend_q  <= pend_d;
			plast_q <= plast_d;
			ov_q    <= ov_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			ostat_q  <= ld_stat;
			oval_q   <= ld_val;
			ofront_q <= ld_front;
			orear_q  <= ld_rear;
			olast_q  <= ld_last;
		end
	end

	assign out_valid  = ov_q;
	assign out_status = ostat_q;
	assign out_value  = oval_q;
	assign out_front  = ofront_q;
	assign out_rear   = orear_q;
	assign out_last   = olast_q;

	assign stat.busy = (state_q != cfq_pkg::S_IDLE);
	assign stat.held = held_q;

endmodule

### hw/rtl/circular_fifo_queue.sv
// Top level of the circular FIFO queue: capacity register, controller and slot memory.
//
// Ring-buffer queue of signed 32-bit words held in a DEPTH-entry synchronous memory,
// of which the first "capacity" slots are used. Each input item carries an operation
// in s_tuser (insert, remove, show) and a word in s_tdata. A successful insert gives
// no result. An insert into a full queue, and a remove or show on an empty one, give
// one status-only result. A remove runs in steps before the next item can be accepted:
// accept and move the pointers, read the memory, load the output register. A show of
// n held words (at most 16 results) streams them out one per cycle while m_tready
// stays high, paced by the single memory read port and its registered read; the run
// stalls without loss while m_tready is low. Results wait in an output register, so
// the next item is accepted in the same cycle that the pending result is taken. The
// user must write the capacity through the cfg channel only while the queue is idle;
// the block itself does not enforce it. Zero is taken as one, values above DEPTH as
// DEPTH, and every write empties the queue while keeping the slot contents. After
// reset the capacity is the smaller of DEPTH and 16.
module circular_fifo_queue #(
	parameter int DEPTH = cfq_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] data
	input  logic [1:0]  s_tuser,   // [1:0] kind
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] value, [35:32] front_pos, [39:36] rear_pos
	output logic [1:0]  m_tuser,   // [1:0] status
	output logic        m_tlast,   // last
	// capacity register write
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [4:0]  cfg_data   // [4:0] capacity
);

	localparam int CW = cfq_pkg::CAP_W;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [CW-1:0]              cap_q;
	logic [CW-1:0]              cap_clamped;
	cfq_pkg::cfg_wr_t           cfg_wr;
	cfq_pkg::ctrl_stat_t        stat;

	logic                       mem_we, mem_re;
	logic [AW-1:0]              mem_waddr, mem_raddr;
	logic [cfq_pkg::DATA_W-1:0] mem_wdata, mem_rdata;

	logic [cfq_pkg::POS_W-1:0]  out_front, out_rear;
	logic [cfq_pkg::DATA_W-1:0] out_value;

	// Always take configuration; the user must send it only while idle, and the block does not enforce it.
	assign cfg_ready = 1'b1;

	// Clamp the written capacity into 1..DEPTH.
	always_comb begin
		if (cfg_data == '0) begin
			cap_clamped = CW'(1);
		end else if (int'(cfg_data) > DEPTH) begin
			cap_clamped = CW'(DEPTH);
		end else begin
			cap_clamped = cfg_data;
		end
	end

	assign cfg_wr.wr      = cfg_valid && cfg_ready;
	assign cfg_wr.cap_new = cap_clamped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= cfq_pkg::cap_reset(DEPTH);
		end else if (cfg_wr.wr) begin
			cap_q <= cap_clamped;
		end
	end

	cfq_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cap        (cap_q),
		.cfg        (cfg_wr),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_kind    (s_tuser),
		.in_data    (s_tdata),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_status (m_tuser),
		.out_value  (out_value),
		.out_front  (out_front),
		.out_rear   (out_rear),
		.out_last   (m_tlast),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.stat       (stat)
	);

	cfq_ram #(
		.DEPTH  (DEPTH),
		.DATA_W (cfq_pkg::DATA_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign m_tdata = {out_rear, out_front, out_value};

	// Capacity stays inside 1..DEPTH.
	a_cap_range: assert property (@(posedge clk) disable iff (!arst_n)
		cap_q != '0 && int'(cap_q) <= DEPTH)
		else $error("capacity out of range");

	// The queue never holds more words than its capacity.
	a_held_le_cap: assert property (@(posedge clk) disable iff (!arst_n)
		stat.held <= cap_q)
		else $error("held count above capacity");

	// No item is taken while a remove or show is still being sequenced.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> !stat.busy)
		else $error("item accepted while busy");

	// An insert into a queue with room adds exactly one word.
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == cfq_pkg::KIND_INSERT
		&& stat.held < cap_q && !cfg_valid
		|=> stat.held == $past(stat.held) + CW'(1))
		else $error("insert did not advance held count");

endmodule

### verif/testbench.sv
// Self-checking testbench for the circular FIFO queue: scoreboard, stimulus and stall control.
`timescale 1ns / 1ps

module testbench;

	localparam int          RING          = cfq_pkg::DEPTH_DEF;  // storage depth of the instance
	localparam int          SETTLE_CYCLES = 8;          // quiet time after the last result
	localparam logic [1:0]  KIND_UNUSED   = 2'd3;       // kind code the block must ignore
	localparam int          PHASE_ITEMS   = 28;         // items per random capacity phase

	// One result item as the scoreboard holds it.
	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] value;
		logic [3:0]  front_pos;
		logic [3:0]  rear_pos;
		logic        last;
	} result_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [31:0] data
	logic [1:0]  s_tuser;   // [1:0] kind
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [31:0] value, [35:32] front_pos, [39:36] rear_pos
	logic [1:0]  m_tuser;   // [1:0] status
	logic        m_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [4:0]  cfg_data;  // [4:0] capacity

	// Mirror of the queue state, updated at each accepted item.
	logic [31:0] mirror_slot [RING];
	logic [3:0]  mirror_front;
	logic [3:0]  mirror_rear;
	int          mirror_held;
	int          mirror_cap;

	// Results still owed by the block, oldest first.
	result_t     awaited [$];

	// Idling controls shared between the stimulus and the receiver.
	bit          tx_quiet;
	bit          rx_quiet;
	int          rx_hold;

	int          n_sent;
	int          n_results;
	int          n_cfg;
	int          n_full;
	int          n_empty;
	int          n_show;
	int          n_errors;

	circular_fifo_queue u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop in case the block hangs a handshake.
	initial begin
		#4_000_000;
		$display("%0t: timeout, %0d results still awaited", $realtime, awaited.size());
		$display("testbench: done, errors");
		$finish;
	end

	function automatic int draw_gap(input bit quiet);
		return quiet ? 0 : $urandom_range(0, 13);
	endfunction

	// Favor the sign and zero extremes, otherwise any word.
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [3:0] ring_next(input logic [3:0] idx);
		int n;
		n = idx + 1;
		return (n >= mirror_cap) ? 4'd0 : 4'(n);
	endfunction

	// Empty the mirror; slot contents stay as they are.
	function automatic void clear_mirror();
		mirror_front = 4'd0;
		mirror_rear  = 4'(mirror_cap - 1);
		mirror_held  = 0;
	endfunction

	function automatic void owe_result(input logic [1:0] status, input logic [31:0] value,
			input logic [3:0] fpos, input logic [3:0] rpos, input logic last);
		result_t r;
		r.status    = status;
		r.value     = value;
		r.front_pos = fpos;
		r.rear_pos  = rpos;
		r.last      = last;
		awaited.push_back(r);
	endfunction

	// Advance the mirror by one accepted item and queue the results it causes.
	function automatic void apply_queue_op(input logic [1:0] op, input logic [31:0] word);
		logic [31:0] head_word;
		logic [3:0]  pos;
		case (op)
			cfq_pkg::KIND_INSERT: begin
				if (mirror_held >= mirror_cap) begin
					owe_result(cfq_pkg::ST_FULL, 32'd0, 4'd0, 4'd0, 1'b1);
				end else begin
					mirror_rear = ring_next(mirror_rear);
					mirror_slot[mirror_rear] = word;
					mirror_held++;
				end
			end
			cfq_pkg::KIND_REMOVE: begin
				if (mirror_held == 0) begin
					owe_result(cfq_pkg::ST_EMPTY, 32'd0, 4'd0, 4'd0, 1'b1);
				end else begin
					head_word = mirror_slot[mirror_front];
					// Taking the final word puts both pointers back home.
					if (mirror_held == 1) begin
						clear_mirror();
					end else begin
						mirror_front = ring_next(mirror_front);
						mirror_held--;
					end
					owe_result(cfq_pkg::ST_OK, head_word, 4'd0, 4'd0, 1'b1);
				end
			end
			cfq_pkg::KIND_SHOW: begin
				if (mirror_held == 0) begin
					owe_result(cfq_pkg::ST_EMPTY, 32'd0, 4'd0, 4'd0, 1'b1);
				end else begin
					n_show++;
					pos = mirror_front;
					for (int i = 0; i < mirror_held; i++) begin
						owe_result(cfq_pkg::ST_OK, mirror_slot[pos], mirror_front,
							mirror_rear, (i + 1 == mirror_held));
						pos = ring_next(pos);
					end
				end
			end
			default: begin
				// unused kind: nothing happens
			end
		endcase
	endfunction

	// Offer one item after a random gap and hold it until taken. Valid stays high on return,
	// so the caller either sends again or lowers it in the same step.
	task automatic send_item(input logic [1:0] op, input logic [31:0] word);
		int gap;
		gap = draw_gap(tx_quiet);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= word;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		apply_queue_op(op, word);
		if (op != KIND_UNUSED) n_sent++;
	endtask

	// Drop valid, wait for every owed result, then let trailing inserts finish.
	task automatic settle_idle();
		s_tvalid <= 1'b0;
		while (awaited.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [4:0] value);
		int c;
		settle_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		// Zero means one, anything past the depth means the depth.
		c = value;
		if (c == 0) c = 1;
		if (c > RING) c = RING;
		mirror_cap = c;
		clear_mirror();
		n_cfg++;
	endtask

	// Receiver: a random wait per result, with an optional long hold counted here.
	initial begin
		int rx_gap;
		m_tready = 1'b0;
		rx_gap   = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rx_hold > 0) begin
				rx_hold--;
				m_tready <= 1'b0;
			end else if (m_tready && m_tvalid) begin
				rx_gap = draw_gap(rx_quiet);
				m_tready <= (rx_gap == 0);
			end else if (!m_tready) begin
				if (rx_gap > 0) rx_gap--;
				if (rx_gap == 0) m_tready <= 1'b1;
			end
		end
	end

	// Scoreboard: compare each taken result with the oldest owed one.
	initial begin
		result_t got;
		result_t want;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got.status    = m_tuser;
				got.value     = m_tdata[31:0];
				got.front_pos = m_tdata[35:32];
				got.rear_pos  = m_tdata[39:36];
				got.last      = m_tlast;
				n_results++;
				if (awaited.size() == 0) begin
					n_errors++;
					$display("%0t: unexpected result, expected none", $realtime);
					$display("  actual   status %0d value %h front %0d rear %0d last %0b",
						got.status, got.value, got.front_pos, got.rear_pos, got.last);
				end else begin
					want = awaited.pop_front();
					if (want.status == cfq_pkg::ST_FULL) n_full++;
					if (want.status == cfq_pkg::ST_EMPTY) n_empty++;
					if (got !== want) begin
						n_errors++;
						$display("%0t: result mismatch", $realtime);
						$display("  expected status %0d value %h front %0d rear %0d last %0b",
							want.status, want.value, want.front_pos, want.rear_pos,
							want.last);
						$display("  actual   status %0d value %h front %0d rear %0d last %0b",
							got.status, got.value, got.front_pos, got.rear_pos,
							got.last);
					end
				end
			end
		end
	end

	// Empty queue at reset capacity: status-only answers, ignored kind, one round trip.
	task automatic test_empty_queue();
		send_item(cfq_pkg::KIND_REMOVE, 32'h1234_5678);
		send_item(cfq_pkg::KIND_SHOW, 32'hffff_ffff);
		send_item(KIND_UNUSED, 32'hdead_beef);
		send_item(cfq_pkg::KIND_INSERT, 32'h8000_0000);
		send_item(cfq_pkg::KIND_SHOW, 32'h0);
		send_item(cfq_pkg::KIND_REMOVE, 32'h0);
		send_item(cfq_pkg::KIND_SHOW, 32'h0);
	endtask

	// Small capacities: full answer, rear wrap, pointer return, zero taken as one.
	task automatic test_capacity_edges();
		set_capacity(5'd3);
		send_item(cfq_pkg::KIND_INSERT, 32'h8000_0000);
		send_item(cfq_pkg::KIND_INSERT, 32'h7fff_ffff);
		send_item(cfq_pkg::KIND_INSERT, 32'h0000_0000);
		send_item(cfq_pkg::KIND_INSERT, 32'hffff_ffff);
		send_item(cfq_pkg::KIND_SHOW, 32'h0);
		send_item(cfq_pkg::KIND_REMOVE, 32'h0);
		send_item(cfq_pkg::KIND_INSERT, 32'h5555_5555);
		send_item(cfq_pkg::KIND_SHOW, 32'h0);
		send_item(cfq_pkg::KIND_REMOVE, 32'h0);
		send_item(cfq_pkg::KIND_REMOVE, 32'h0);
		send_item(cfq_pkg::KIND_REMOVE, 32'h0);
		send_item(cfq_pkg::KIND_REMOVE, 32'h0);
		set_capacity(5'd0);
		send_item(cfq_pkg::KIND_INSERT, 32'haaaa_aaaa);
		send_item(cfq_pkg::KIND_INSERT, 32'h0f0f_0f0f);
		send_item(cfq_pkg::KIND_SHOW, 32'h0);
		send_item(cfq_pkg::KIND_REMOVE, 32'h0);
	endtask

	// Hold the receiver off with a full queue so the show run backs up the input.
	task automatic test_output_stall();
		set_capacity(5'd16);
		tx_quiet = 1'b1;
		rx_quiet = 1'b1;
		repeat (16) send_item(cfq_pkg::KIND_INSERT, pick_word());
		rx_hold = 300;
		send_item(cfq_pkg::KIND_SHOW, 32'h0);
		send_item(cfq_pkg::KIND_REMOVE, 32'h0);
		send_item(cfq_pkg::KIND_SHOW, 32'h0);
		send_item(cfq_pkg::KIND_REMOVE, 32'h0);
		send_item(cfq_pkg::KIND_INSERT, pick_word());
		send_item(cfq_pkg::KIND_SHOW, 32'h0);
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	// Random phases over several capacities: fill and drain runs with random words, plus noise.
	task automatic test_random_mix();
		int caps [12];
		int phase_start;
		int k;
		int r;
		caps = '{31, 1, 2, 16, 5, 8, 17, 15, 4, 0, 7, 3};
		caps[$urandom_range(1, 11)] = $urandom_range(1, 16);
		for (int p = 0; p < 12; p++) begin
			set_capacity(5'(caps[p]));
			tx_quiet    = ($urandom_range(0, 3) == 0);
			rx_quiet    = ($urandom_range(0, 3) == 0);
			phase_start = n_sent;
			while (n_sent - phase_start < PHASE_ITEMS) begin
				case ($urandom_range(0, 9))
					0, 1, 2: begin
						// fill up, sometimes one past full
						k = mirror_cap - mirror_held + $urandom_range(0, 1);
						repeat (k) send_item(cfq_pkg::KIND_INSERT, pick_word());
						if ($urandom_range(0, 1)) send_item(cfq_pkg::KIND_SHOW, $urandom);
					end
					3, 4: begin
						// drain, sometimes one past empty
						k = mirror_held + $urandom_range(0, 1);
						repeat (k) send_item(cfq_pkg::KIND_REMOVE, $urandom);
					end
					5: send_item(cfq_pkg::KIND_SHOW, $urandom);
					6: send_item(KIND_UNUSED, $urandom);
					default: begin
						repeat (4) begin
							r = $urandom_range(0, 99);
							if (r < 45) send_item(cfq_pkg::KIND_INSERT, pick_word());
							else if (r < 75) send_item(cfq_pkg::KIND_REMOVE, $urandom);
							else if (r < 95) send_item(cfq_pkg::KIND_SHOW, $urandom);
							else send_item(KIND_UNUSED, $urandom);
						end
					end
				endcase
			end
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = 32'd0;
		s_tuser   = cfq_pkg::KIND_INSERT;
		cfg_valid = 1'b0;
		cfg_data  = 5'd0;
		tx_quiet  = 1'b0;
		rx_quiet  = 1'b0;
		rx_hold   = 0;
		n_sent    = 0;
		n_results = 0;
		n_cfg     = 0;
		n_full    = 0;
		n_empty   = 0;
		n_show    = 0;
		n_errors  = 0;
		// Reset capacity is the depth, capped at sixteen.
		mirror_cap = (RING < 16) ? RING : 16;
		clear_mirror();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue();
		test_capacity_edges();
		test_output_stall();
		test_random_mix();

		settle_idle();
		repeat (16) @(posedge clk);
		$display("summary: %0d items sent, %0d results checked, %0d capacity writes",
			n_sent, n_results, n_cfg);
		$display("summary: %0d full and %0d empty answers, %0d show runs, one long output hold",
			n_full, n_empty, n_show);
		if (n_errors == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
